// ===== design/ps2kbd_pkg.sv =====
package ps2kbd_pkg;

   typedef enum logic [1:0] {
      ACT_SCAN = 2'd0,
      ACT_LOAD = 2'd1,
      ACT_READ = 2'd2
   } action_type;

   localparam logic [7:0] CODE_BREAK  = 8'hF0;
   localparam logic [7:0] CODE_EXT    = 8'hE0;
   localparam logic [7:0] CODE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;

   localparam logic [1:0] MAP_UNSHIFT = 2'd0;
   localparam logic [1:0] MAP_SHIFT   = 2'd1;
   localparam logic [1:0] MAP_EXT     = 2'd2;

   localparam int KEYMAP_DEPTH = 768;
   localparam int KEYMAP_AW    = 10;
   localparam int CHAR_W       = 8;
   localparam int QUEUED_W     = 5;

   typedef struct packed {
      logic                 wr_en;
      logic [KEYMAP_AW-1:0] wr_addr;
      logic [CHAR_W-1:0]    wr_data;
      logic                 rd_en;
      logic [KEYMAP_AW-1:0] rd_addr;
   } keymap_req_type;

   typedef struct packed {
      logic lookup;
      logic is_read;
      logic shift;
   } stage_ctl_type;

   typedef struct packed {
      logic                char_valid;
      logic [QUEUED_W-1:0] queued;
      logic                shift;
      logic                dropped;
   } result_type;

endpackage

// ===== design/ps2kbd_ram.sv =====
module ps2kbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ps2kbd_scan.sv =====
module ps2kbd_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  ps2kbd_pkg::action_type     action,
   input  logic [7:0]                 scan_byte,
   input  logic [1:0]                 map_select,
   input  logic [7:0]                 map_char,
   output ps2kbd_pkg::keymap_req_type mem_req,
   output ps2kbd_pkg::stage_ctl_type  ctl,
   output logic                       busy
);
   import ps2kbd_pkg::*;

   logic                 break_ff, break_in;
   logic                 extend_ff, extend_in;
   logic                 shift_ff, shift_in;
   logic                 clear_active_ff, clear_active_in;
   logic [KEYMAP_AW-1:0] clear_addr_ff, clear_addr_in;
   logic                 is_shift_code;
   logic [1:0]           lookup_map;

   assign is_shift_code = (scan_byte == CODE_LSHIFT) || (scan_byte == CODE_RSHIFT);
   assign lookup_map = extend_ff ? MAP_EXT : (shift_ff ? MAP_SHIFT : MAP_UNSHIFT);

   always_comb begin
      break_in        = break_ff;
      extend_in       = extend_ff;
      shift_in        = shift_ff;
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      mem_req         = '0;
      ctl.lookup      = 1'b0;
      ctl.is_read     = 1'b0;
      if (clear_active_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = clear_addr_ff;
         clear_addr_in   = clear_addr_ff + KEYMAP_AW'(1);
         if (clear_addr_ff == KEYMAP_AW'(KEYMAP_DEPTH - 1)) begin
            clear_active_in = 1'b0;
         end
      end else if (accept) begin
         case (action)
            ACT_SCAN: begin
               if (break_ff) begin
                  break_in  = 1'b0;
                  extend_in = 1'b0;
                  if (is_shift_code) begin
                     shift_in = 1'b0;
                  end
               end else if (scan_byte == CODE_BREAK) begin
                  break_in = 1'b1;
               end else if (scan_byte == CODE_EXT) begin
                  extend_in = 1'b1;
               end else if (is_shift_code) begin
                  shift_in = 1'b1;
               end else begin
                  extend_in       = 1'b0;
                  ctl.lookup      = 1'b1;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = {lookup_map, scan_byte};
               end
            end
            ACT_LOAD: begin
               if (map_select == MAP_UNSHIFT || map_select == MAP_SHIFT ||
                   map_select == MAP_EXT) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = {map_select, scan_byte};
                  mem_req.wr_data = map_char;
               end
            end
            ACT_READ: begin
               ctl.is_read = 1'b1;
            end
            default: begin
            end
         endcase
      end
      ctl.shift = shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         break_ff        <= 1'b0;
         extend_ff       <= 1'b0;
         shift_ff        <= 1'b0;
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         break_ff        <= break_in;
         extend_ff       <= extend_in;
         shift_ff        <= shift_in;
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
      end
   end

   assign busy = clear_active_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (accept && !clear_active_ff && action == ACT_SCAN && break_ff) |=> !break_ff)
      else $error("Break prefix was not consumed by the following scan byte.");

   assert property (@(posedge clock) disable iff (reset)
      (clear_active_ff && accept) |=> $stable(shift_ff) && $stable(extend_ff))
      else $error("Key state changed while the key map was being cleared.");
`endif

endmodule

// ===== design/ps2kbd_fifo.sv =====
module ps2kbd_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  ps2kbd_pkg::stage_ctl_type ctl,
   input  logic [7:0]                key_char,
   output ps2kbd_pkg::result_type    result,
   output logic [7:0]                head_char
);
   import ps2kbd_pkg::*;

   localparam int IDX_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push_try;
   logic             full;
   logic             not_empty;
   logic             push;
   logic             pop;

   assign push_try  = ctl.lookup && (key_char != '0);
   assign full      = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign push      = enable && push_try && !full;
   assign pop       = enable && ctl.is_read && not_empty;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0 : wr_idx_ff + IDX_W'(1);
         fill_in   = fill_ff + CNT_W'(1);
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0 : rd_idx_ff + IDX_W'(1);
         fill_in   = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
   end

   ps2kbd_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (FIFO_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_idx_ff),
      .wr_data (key_char),
      .rd_en   (pop),
      .rd_addr (rd_idx_ff),
      .rd_data (head_char)
   );

   assign result.char_valid = ctl.is_read && not_empty;
   assign result.queued     = QUEUED_W'(fill_in);
   assign result.shift      = ctl.shift;
   assign result.dropped    = push_try && full;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(FIFO_DEPTH))
      else $error("Character queue count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("Character queue pushed and popped by the same request.");
`endif

endmodule

// ===== design/ps2_keyboard_scan_decoder.sv =====
// PS/2 scan code set 2 keyboard decoder with a character queue.
// Requests arrive on the req_ stream: req_tuser carries the action (scan byte,
// map load or character read) and req_tdata the scan byte, map select and map
// character. Every request produces exactly one response on the rsp_ stream,
// in order, with the popped character, the queue count, the shift state and a
// drop flag.
// A request is registered in the input stage, where the key map memory is
// looked up, and then moves into the response register, which drives
// rsp_tvalid. One request is taken every cycle while the key map is not
// being cleared and the receiver keeps rsp_tready high.
// After reset the key map is cleared one entry per cycle, all 768 entries;
// req_tready stays low during that pass. The key state, the shift
// state and the character queue start empty.
// When the receiver holds rsp_tready low, the response register keeps its
// value and the input stage still takes one more request, after which
// req_tready falls until the response is taken.
module ps2_keyboard_scan_decoder #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // scan_byte[7:0], map_select[9:8], map_char[17:10], zero
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // char_out[7:0], queued_count[12:8], shift_active[13],
                                   // char_dropped[14], zero
   output logic [0:0]  rsp_tuser   // char_valid[0]
);
   import ps2kbd_pkg::*;

   logic           accept;
   logic           advance;
   logic           busy;
   keymap_req_type mem_req;
   stage_ctl_type  ctl;
   logic [7:0]     key_char;
   logic [7:0]     head_char;
   result_type     result;

   logic           s1_valid_ff, s1_valid_in;
   stage_ctl_type  s1_ctl_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_result_ff;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   ps2kbd_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (action_type'(req_tuser)),
      .scan_byte  (req_tdata[7:0]),
      .map_select (req_tdata[9:8]),
      .map_char   (req_tdata[17:10]),
      .mem_req    (mem_req),
      .ctl        (ctl),
      .busy       (busy)
   );

   ps2kbd_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (KEYMAP_DEPTH)
   ) u_keymap_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (key_char)
   );

   ps2kbd_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .ctl       (s1_ctl_ff),
      .key_char  (key_char),
      .result    (result),
      .head_char (head_char)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_ctl_ff <= ctl;
      end
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff.dropped, rsp_result_ff.shift,
                        rsp_result_ff.queued,
                        rsp_result_ff.char_valid ? head_char : 8'h00};
   assign rsp_tuser  = rsp_result_ff.char_valid;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("Request accepted while the key map was being cleared.");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_ctl_ff))
      else $error("Stalled request was lost from the input stage.");
`endif

endmodule
